>>> rtl/s2l_pkg.sv
// Shared constants and elaboration-time helpers for the sRGB to LCh converter.
// Depends on nothing; used by every module in rtl/.
package s2l_pkg;

  // Result bits of the chroma square root (isqrt of up to 29 * 2^32)
  localparam int SQRT_STEPS = 19;

  // Result bits of the cube root (0..65536)
  localparam int CBRT_STEPS = 17;

  // RGB-to-XYZ rows, Q0.16, each row sums to 65536
  localparam logic [15:0] MAT [3][3] = '{
    '{16'd28435, 16'd24656, 16'd12445},
    '{16'd13933, 16'd46871, 16'd4732},
    '{16'd1162,  16'd7173,  16'd57201}
  };

  // CORDIC arctangent steps, 2^32 = 2 pi
  localparam logic [31:0] ATAN_UNITS [24] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10680862,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41721,     32'd20860,
    32'd10430,     32'd5215,      32'd2607,      32'd1303,
    32'd651,       32'd325,       32'd162,       32'd81
  };

  // Gamma table entry k: round(65536 * (k/2^bits)^2.2), built as
  // k^2 * floor(65536 * fifth root) with the fifth root found exactly.
  // Evaluated at elaboration only.
  function automatic logic [16:0] gamma_entry(input int unsigned k,
                                              input int unsigned bits);
    logic [127:0] lo;
    logic [127:0] hi;
    logic [127:0] mid;
    logic [127:0] th;
    logic [127:0] p;
    logic [127:0] kk;
    logic [127:0] res;
    lo = '0;
    hi = 128'd65536;
    kk = 128'(k);
    th = kk << (80 - bits);
    for (int it = 0; it < 18; it++) begin
      if (lo < hi) begin
        mid = (lo + hi + 128'd1) >> 1;
        p = mid * mid * mid * mid * mid;
        if (p <= th) begin
          lo = mid;
        end else begin
          hi = mid - 128'd1;
        end
      end
    end
    res = (kk * kk * lo + (128'd1 << (2 * bits - 1))) >> (2 * bits);
    return res[16:0];
  endfunction

endpackage

>>> rtl/s2l_cbrt.sv
// Pipelined cube root: root = floor(cbrt(w * 2^32)), one result bit per stage.
// Depends on s2l_pkg.
module s2l_cbrt (
  input  logic        clk,
  input  logic [16:0] w,
  output logic [16:0] root
);

  localparam int N = s2l_pkg::CBRT_STEPS;

  logic [16:0] cr  [N+1];
  logic [33:0] cr2 [N+1];
  logic [51:0] cr3 [N+1];
  logic [48:0] cn  [N+1];

  // Seed the digit recurrence
  assign cr[0]  = '0;
  assign cr2[0] = '0;
  assign cr3[0] = '0;
  assign cn[0]  = {w, 32'd0};

  // Try one result bit per stage, tracking root, root^2 and root^3
  for (genvar j = 0; j < N; j++) begin : g_step
    localparam int SH = N - 1 - j;
    logic [51:0] t2;
    logic [51:0] t1;
    logic [51:0] c3;
    logic [33:0] c2;
    assign t2 = {18'd0, cr2[j]} << SH;
    assign t1 = {35'd0, cr[j]} << (2 * SH);
    assign c3 = cr3[j] + t2 + (t2 << 1) + t1 + (t1 << 1) + (52'd1 << (3 * SH));
    assign c2 = cr2[j] + ({17'd0, cr[j]} << (SH + 1)) + (34'd1 << (2 * SH));
    always_ff @(posedge clk) begin
      cn[j+1] <= cn[j];
      if (c3 <= {3'd0, cn[j]}) begin
        cr[j+1]  <= cr[j] | (17'd1 << SH);
        cr2[j+1] <= c2;
        cr3[j+1] <= c3;
      end else begin
        cr[j+1]  <= cr[j];
        cr2[j+1] <= cr2[j];
        cr3[j+1] <= cr3[j];
      end
    end
  end

  assign root = cr[N];

endmodule

>>> rtl/s2l_polar.sv
// Polar conversion of (a, b): chroma by a pipelined square root and hue by a
// pipelined vectoring CORDIC, run side by side. Depends on s2l_pkg.
module s2l_polar #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic               clk,
  input  logic signed [19:0] a,
  input  logic signed [19:0] b,
  output logic        [15:0] chroma,
  output logic signed [15:0] hue_angle
);

  localparam int D = (CORDIC_STAGES > s2l_pkg::SQRT_STEPS) ?
                     CORDIC_STAGES : s2l_pkg::SQRT_STEPS;
  localparam int SQ = s2l_pkg::SQRT_STEPS;

  logic        [36:0] sq_a;
  logic        [36:0] sq_b;
  logic signed [19:0] a_d;
  logic signed [19:0] b_d;
  logic signed [39:0] pa;
  logic signed [39:0] pb;

  logic        [18:0] sr  [D+1];
  logic        [38:0] sr2 [D+1];
  logic        [38:0] sn  [D+1];
  logic signed [31:0] cx  [D+1];
  logic signed [31:0] cy  [D+1];
  logic        [31:0] cz  [D+1];

  logic signed [31:0] x0;
  logic signed [31:0] y0;
  logic        [19:0] ch_round;
  logic        [31:0] z_round;

  // Square both components
  assign pa = a * a;
  assign pb = b * b;
  always_ff @(posedge clk) begin
    sq_a <= pa[36:0];
    sq_b <= pb[36:0];
    a_d  <= a;
    b_d  <= b;
  end

  // Sum the squares; fold the vector into the right half plane
  assign x0 = {{4{b_d[19]}}, b_d, 8'd0};
  assign y0 = {{4{a_d[19]}}, a_d, 8'd0};
  always_ff @(posedge clk) begin
    sr[0]  <= '0;
    sr2[0] <= '0;
    sn[0]  <= {2'd0, sq_a} + {2'd0, sq_b};
    if (x0 < 0) begin
      cx[0] <= -x0;
      cy[0] <= -y0;
      cz[0] <= 32'h8000_0000;
    end else begin
      cx[0] <= x0;
      cy[0] <= y0;
      cz[0] <= '0;
    end
  end

  for (genvar j = 0; j < D; j++) begin : g_stage
    // Square root: try one result bit, tracking root and root^2
    if (j < SQ) begin : g_sq
      localparam int SH = SQ - 1 - j;
      logic [38:0] cand;
      assign cand = sr2[j] + ({20'd0, sr[j]} << (SH + 1)) + (39'd1 << (2 * SH));
      always_ff @(posedge clk) begin
        sn[j+1] <= sn[j];
        if (cand <= sn[j]) begin
          sr[j+1]  <= sr[j] | (19'd1 << SH);
          sr2[j+1] <= cand;
        end else begin
          sr[j+1]  <= sr[j];
          sr2[j+1] <= sr2[j];
        end
      end
    end else begin : g_sq_hold
      always_ff @(posedge clk) begin
        sn[j+1]  <= sn[j];
        sr[j+1]  <= sr[j];
        sr2[j+1] <= sr2[j];
      end
    end

    // CORDIC: rotate toward y = 0, no move when y is already zero
    if (j < CORDIC_STAGES) begin : g_cor
      logic signed [31:0] dx;
      logic signed [31:0] dy;
      assign dx = cy[j] >>> j;
      assign dy = cx[j] >>> j;
      always_ff @(posedge clk) begin
        if (cy[j] > 0) begin
          cx[j+1] <= cx[j] + dx;
          cy[j+1] <= cy[j] - dy;
          cz[j+1] <= cz[j] + s2l_pkg::ATAN_UNITS[j];
        end else if (cy[j] < 0) begin
          cx[j+1] <= cx[j] - dx;
          cy[j+1] <= cy[j] + dy;
          cz[j+1] <= cz[j] - s2l_pkg::ATAN_UNITS[j];
        end else begin
          cx[j+1] <= cx[j];
          cy[j+1] <= cy[j];
          cz[j+1] <= cz[j];
        end
      end
    end else begin : g_cor_hold
      always_ff @(posedge clk) begin
        cx[j+1] <= cx[j];
        cy[j+1] <= cy[j];
        cz[j+1] <= cz[j];
      end
    end
  end

  // Round and saturate chroma, round the angle to 16 bits
  assign ch_round = {1'b0, sr[D]} + 20'd4;
  assign z_round  = cz[D] + 32'h0000_8000;
  always_ff @(posedge clk) begin
    chroma    <= (ch_round[19] == 1'b1) ? 16'hFFFF : ch_round[18:3];
    hue_angle <= z_round[31:16];
  end

endmodule

>>> rtl/srgb_to_lch_converter_unit.sv
// sRGB to LCh pixel converter: gamma 2.2 table, RGB-to-XYZ, cube roots, polar.
// One word per cycle sustained. The depth is set by the cube-root digit
// pipeline and the longer of the square-root digit pipeline and the CORDIC,
// the digit pipelines giving one result bit per stage. busy never rises.
// Reset clears only the valid chain; words in flight at reset are dropped.
// Depends on s2l_pkg, s2l_cbrt, s2l_polar.
module srgb_to_lch_converter_unit #(
  parameter int GAMMA_TABLE_BITS = 10,
  parameter int CORDIC_STAGES    = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] red_in,
  input  logic signed [15:0] green_in,
  input  logic signed [15:0] blue_in,
  output logic               done,
  output logic        [15:0] lightness,
  output logic        [15:0] chroma,
  output logic signed [15:0] hue_angle
);

  localparam int B       = GAMMA_TABLE_BITS;
  localparam int DEPTH   = (1 << B) + 1;
  localparam int D       = (CORDIC_STAGES > s2l_pkg::SQRT_STEPS) ?
                           CORDIC_STAGES : s2l_pkg::SQRT_STEPS;
  localparam int LAT     = D + 25;
  localparam int L_DELAY = D + 4;

  logic [16:0] gamma_rom [DEPTH];
  logic [15:0] raw [3];
  logic [14:0] vcl [3];
  logic [B:0]  k0  [3];
  logic [B:0]  k1  [3];
  logic [14+B:0] sfr [3];

  logic [16:0] e0   [3];
  logic [16:0] e1   [3];
  logic [13:0] frac [3];
  logic [16:0] lin  [3];
  logic [32:0] prod [3][3];
  logic [16:0] xyz  [3];
  logic [16:0] fr   [3];

  logic signed [19:0] a_r;
  logic signed [19:0] b_r;
  logic        [15:0] ldly [L_DELAY];
  logic [LAT-1:0]     vld;

  // Build the gamma table at elaboration
  for (genvar k = 0; k < DEPTH; k++) begin : g_rom
    assign gamma_rom[k] = s2l_pkg::gamma_entry(k, B);
  end

  assign raw[0] = red_in;
  assign raw[1] = green_in;
  assign raw[2] = blue_in;

  for (genvar c = 0; c < 3; c++) begin : g_chan
    // Clamp to 0..1 and split into table index and interpolation fraction
    always_comb begin
      if (raw[c][15]) begin
        vcl[c] = '0;
      end else if (raw[c][14:0] > 15'd16384) begin
        vcl[c] = 15'd16384;
      end else begin
        vcl[c] = raw[c][14:0];
      end
    end
    assign k0[c]  = vcl[c][14:14-B];
    assign k1[c]  = (k0[c] == (B+1)'(DEPTH - 1)) ? k0[c] : k0[c] + 1'b1;
    assign sfr[c] = {vcl[c], {B{1'b0}}};

    // Read both neighboring table entries
    always_ff @(posedge clk) begin
      e0[c]   <= gamma_rom[k0[c]];
      e1[c]   <= gamma_rom[k1[c]];
      frac[c] <= sfr[c][13:0];
    end

    // Interpolate between entries, rounded
    logic [30:0] dprod;
    logic [31:0] dsum;
    assign dprod = (e1[c] - e0[c]) * frac[c];
    assign dsum  = {1'b0, dprod} + 32'd8192;
    always_ff @(posedge clk) begin
      lin[c] <= e0[c] + dsum[30:14];
    end
  end

  // Matrix products, one multiplier per coefficient
  for (genvar r = 0; r < 3; r++) begin : g_row
    for (genvar c = 0; c < 3; c++) begin : g_col
      always_ff @(posedge clk) begin
        prod[r][c] <= s2l_pkg::MAT[r][c] * lin[c];
      end
    end

    // Sum the row and round to Q0.16
    logic [34:0] rsum;
    assign rsum = {2'd0, prod[r][0]} + {2'd0, prod[r][1]} + {2'd0, prod[r][2]}
                  + 35'd32768;
    always_ff @(posedge clk) begin
      xyz[r] <= rsum[32:16];
    end

    s2l_cbrt u_cbrt (
      .clk  (clk),
      .w    (xyz[r]),
      .root (fr[r])
    );
  end

  // Form scaled a and b; saturate lightness
  logic signed [17:0] dxy;
  logic signed [17:0] dyz;
  assign dxy = $signed({1'b0, fr[0]}) - $signed({1'b0, fr[1]});
  assign dyz = $signed({1'b0, fr[1]}) - $signed({1'b0, fr[2]});
  always_ff @(posedge clk) begin
    a_r     <= ({{2{dxy[17]}}, dxy} <<< 2) + {{2{dxy[17]}}, dxy};
    b_r     <= {{2{dyz[17]}}, dyz} <<< 1;
    ldly[0] <= fr[1][16] ? 16'hFFFF : fr[1][15:0];
  end

  // Delay lightness to meet the polar results
  for (genvar i = 1; i < L_DELAY; i++) begin : g_ldly
    always_ff @(posedge clk) begin
      ldly[i] <= ldly[i-1];
    end
  end

  s2l_polar #(
    .CORDIC_STAGES (CORDIC_STAGES)
  ) u_polar (
    .clk       (clk),
    .a         (a_r),
    .b         (b_r),
    .chroma    (chroma),
    .hue_angle (hue_angle)
  );

  // Advance the valid chain alongside the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LAT-2:0], start};
    end
  end

  assign busy      = 1'b0;
  assign done      = vld[LAT-1];
  assign lightness = ldly[L_DELAY-1];

endmodule
